/* rtl/krte_pkg.sv */
// Shared types and codes for the keyed record table engine.
`default_nettype none

package krte_pkg;

	typedef enum logic [2:0] {
		KIND_CLEAR  = 3'd0,
		KIND_APPEND = 3'd1,
		KIND_LIST   = 3'd2,
		KIND_SEARCH = 3'd3,
		KIND_UPDATE = 3'd4,
		KIND_DELETE = 3'd5,
		KIND_INSERT = 3'd6,
		KIND_SORT   = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_BAD_POS   = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_CLEAR, S_APPEND,
		S_CNT_CHK, S_CNT_CMP, S_EM_CHK, S_EM_CMP,
		S_UP_CHK, S_UP_CMP, S_DL_CHK, S_DL_CMP,
		S_IN_CHK, S_IN_CMP,
		S_SO_I, S_SO_LD, S_SO_J, S_SO_CMP,
		S_RESULT
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_START, OP_CLEAR, OP_APPEND, OP_SET_ST,
		OP_RD_I, OP_COUNT, OP_REWIND, OP_EMIT_REC,
		OP_UPDATE, OP_HIT_ST, OP_DELETE, OP_DEL_END,
		OP_RD_INS, OP_MOVE_UP, OP_INS_PUT,
		OP_RD_SLOT, OP_LOAD_A, OP_PUT_A, OP_RD_J, OP_SWAP,
		OP_EMIT_ST
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t status;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  i_end;
		logic  j_end;
		logic  ins_done;
		logic  full;
		logic  bad_pos;
		logic  tot_zero;
		logic  match;
		logic  hit;
		logic  out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/krte_ctrl.sv */
// Sequencer that walks each table operation and drives the datapath.
`default_nettype none

module krte_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  krte_pkg::dp_stat_t   stat,
	output krte_pkg::cmd_t       cmd
);

	krte_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krte_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			krte_pkg::S_IDLE: if (in_valid) state_nx = krte_pkg::S_DECODE;
			krte_pkg::S_DECODE: begin
				unique case (stat.kind)
					krte_pkg::KIND_CLEAR: state_nx = krte_pkg::S_CLEAR;
					krte_pkg::KIND_APPEND:
						state_nx = stat.full ? krte_pkg::S_RESULT : krte_pkg::S_APPEND;
					krte_pkg::KIND_LIST, krte_pkg::KIND_SEARCH: state_nx = krte_pkg::S_CNT_CHK;
					krte_pkg::KIND_UPDATE: state_nx = krte_pkg::S_UP_CHK;
					krte_pkg::KIND_DELETE: state_nx = krte_pkg::S_DL_CHK;
					krte_pkg::KIND_INSERT:
						state_nx = (stat.bad_pos || stat.full) ? krte_pkg::S_RESULT
						                                       : krte_pkg::S_IN_CHK;
					default: state_nx = krte_pkg::S_SO_I;
				endcase
			end
			krte_pkg::S_CLEAR, krte_pkg::S_APPEND: state_nx = krte_pkg::S_RESULT;
			krte_pkg::S_CNT_CHK:
				state_nx = stat.i_end ? krte_pkg::S_EM_CHK : krte_pkg::S_CNT_CMP;
			krte_pkg::S_CNT_CMP: state_nx = krte_pkg::S_CNT_CHK;
			krte_pkg::S_EM_CHK: begin
				if (stat.tot_zero) state_nx = krte_pkg::S_RESULT;
				else if (stat.i_end) state_nx = krte_pkg::S_IDLE;
				else state_nx = krte_pkg::S_EM_CMP;
			end
			krte_pkg::S_EM_CMP:
				if (!(stat.match && stat.out_busy)) state_nx = krte_pkg::S_EM_CHK;
			krte_pkg::S_UP_CHK:
				state_nx = stat.i_end ? krte_pkg::S_RESULT : krte_pkg::S_UP_CMP;
			krte_pkg::S_UP_CMP: state_nx = krte_pkg::S_UP_CHK;
			krte_pkg::S_DL_CHK:
				state_nx = stat.i_end ? krte_pkg::S_RESULT : krte_pkg::S_DL_CMP;
			krte_pkg::S_DL_CMP: state_nx = krte_pkg::S_DL_CHK;
			krte_pkg::S_IN_CHK:
				state_nx = stat.ins_done ? krte_pkg::S_RESULT : krte_pkg::S_IN_CMP;
			krte_pkg::S_IN_CMP: state_nx = krte_pkg::S_IN_CHK;
			krte_pkg::S_SO_I:
				state_nx = stat.i_end ? krte_pkg::S_RESULT : krte_pkg::S_SO_LD;
			krte_pkg::S_SO_LD: state_nx = krte_pkg::S_SO_J;
			krte_pkg::S_SO_J:
				state_nx = stat.j_end ? krte_pkg::S_SO_I : krte_pkg::S_SO_CMP;
			krte_pkg::S_SO_CMP: state_nx = krte_pkg::S_SO_J;
			krte_pkg::S_RESULT: if (!stat.out_busy) state_nx = krte_pkg::S_IDLE;
			default: state_nx = krte_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op     = krte_pkg::OP_NOP;
		cmd.status = krte_pkg::STAT_OK;
		in_ready   = 1'b0;
		unique case (state_q)
			krte_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = krte_pkg::OP_LOAD;
			end
			krte_pkg::S_DECODE: begin
				cmd.op = krte_pkg::OP_START;
				if (stat.kind == krte_pkg::KIND_INSERT && stat.bad_pos)
					cmd.status = krte_pkg::STAT_BAD_POS;
				else if ((stat.kind == krte_pkg::KIND_INSERT ||
				          stat.kind == krte_pkg::KIND_APPEND) && stat.full)
					cmd.status = krte_pkg::STAT_FULL;
			end
			krte_pkg::S_CLEAR:  cmd.op = krte_pkg::OP_CLEAR;
			krte_pkg::S_APPEND: cmd.op = krte_pkg::OP_APPEND;
			krte_pkg::S_CNT_CHK:
				cmd.op = stat.i_end ? krte_pkg::OP_REWIND : krte_pkg::OP_RD_I;
			krte_pkg::S_CNT_CMP: cmd.op = krte_pkg::OP_COUNT;
			krte_pkg::S_EM_CHK: begin
				if (stat.tot_zero) begin
					cmd.op     = krte_pkg::OP_SET_ST;
					cmd.status = (stat.kind == krte_pkg::KIND_LIST) ? krte_pkg::STAT_OK
					                                               : krte_pkg::STAT_NOT_FOUND;
				end else if (!stat.i_end) begin
					cmd.op = krte_pkg::OP_RD_I;
				end
			end
			krte_pkg::S_EM_CMP:
				if (stat.match && !stat.out_busy) cmd.op = krte_pkg::OP_EMIT_REC;
			krte_pkg::S_UP_CHK:
				cmd.op = stat.i_end ? krte_pkg::OP_HIT_ST : krte_pkg::OP_RD_I;
			krte_pkg::S_UP_CMP: cmd.op = krte_pkg::OP_UPDATE;
			krte_pkg::S_DL_CHK:
				cmd.op = stat.i_end ? krte_pkg::OP_DEL_END : krte_pkg::OP_RD_I;
			krte_pkg::S_DL_CMP: cmd.op = krte_pkg::OP_DELETE;
			krte_pkg::S_IN_CHK:
				cmd.op = stat.ins_done ? krte_pkg::OP_INS_PUT : krte_pkg::OP_RD_INS;
			krte_pkg::S_IN_CMP: cmd.op = krte_pkg::OP_MOVE_UP;
			krte_pkg::S_SO_I: if (!stat.i_end) cmd.op = krte_pkg::OP_RD_SLOT;
			krte_pkg::S_SO_LD: cmd.op = krte_pkg::OP_LOAD_A;
			krte_pkg::S_SO_J:
				cmd.op = stat.j_end ? krte_pkg::OP_PUT_A : krte_pkg::OP_RD_J;
			krte_pkg::S_SO_CMP: cmd.op = krte_pkg::OP_SWAP;
			krte_pkg::S_RESULT: if (!stat.out_busy) cmd.op = krte_pkg::OP_EMIT_ST;
			default: cmd.op = krte_pkg::OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/krte_dp.sv */
// Record memory, walk counters, sort holding register and output register.
`default_nettype none

module krte_dp #(
	parameter int TABLE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  krte_pkg::cmd_t       cmd,
	output krte_pkg::dp_stat_t   stat,
	input  wire  [2:0]           kind,
	input  wire  signed [31:0]   record_key,
	input  wire  [31:0]          record_payload,
	input  wire  [4:0]           position,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic signed [31:0]   entry_key,
	output logic [31:0]          entry_payload,
	output logic [1:0]           status,
	output logic                 has_entry,
	output logic [4:0]           entry_count,
	output logic                 last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	logic [31:0]             key_mem [TABLE_DEPTH];
	logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_DEPTH];

	krte_pkg::kind_t         kind_q;
	logic [31:0]             key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [4:0]              pos_q;
	logic [CW-1:0]           count_q, i_q, j_q, tot_q;
	logic                    hit_q;
	krte_pkg::status_t       status_q;
	logic [AW-1:0]           rd_addr_q;
	logic [31:0]             rkey_q;
	logic [PAYLOAD_BITS-1:0] rpay_q;
	logic [31:0]             a_key_q;
	logic [PAYLOAD_BITS-1:0] a_pay_q;

	logic                    we, rd_en;
	logic [AW-1:0]           waddr, raddr;
	logic [31:0]             wkey;
	logic [PAYLOAD_BITS-1:0] wpay;
	logic                    match, greater, out_busy;
	logic [CW-1:0]           pos_c;

	assign pos_c    = CW'(pos_q);
	assign match    = (kind_q == krte_pkg::KIND_LIST) || (rkey_q == key_q);
	assign greater  = $signed(a_key_q) > $signed(rkey_q);
	assign out_busy = out_valid && !out_ready;

	always_comb begin
		stat.kind     = kind_q;
		stat.i_end    = (i_q == count_q);
		stat.j_end    = (j_q == count_q);
		stat.ins_done = (i_q == (count_q - pos_c));
		stat.full     = (count_q == CW'(TABLE_DEPTH));
		stat.bad_pos  = (PW'(pos_q) > PW'(count_q));
		stat.tot_zero = (tot_q == '0);
		stat.match    = match;
		stat.hit      = hit_q;
		stat.out_busy = out_busy;
	end

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = AW'(i_q);
		wkey  = key_q;
		wpay  = pay_q;
		rd_en = 1'b0;
		raddr = AW'(i_q);
		case (cmd.op)
			krte_pkg::OP_APPEND: begin
				we    = 1'b1;
				waddr = AW'(count_q);
			end
			krte_pkg::OP_INS_PUT: begin
				we    = 1'b1;
				waddr = AW'(pos_q);
			end
			krte_pkg::OP_UPDATE: begin
				we    = match;
				waddr = rd_addr_q;
				wkey  = rkey_q;
			end
			krte_pkg::OP_DELETE: begin
				we    = !match;
				waddr = AW'(j_q);
				wkey  = rkey_q;
				wpay  = rpay_q;
			end
			krte_pkg::OP_MOVE_UP: begin
				we    = 1'b1;
				waddr = rd_addr_q + AW'(1);
				wkey  = rkey_q;
				wpay  = rpay_q;
			end
			krte_pkg::OP_PUT_A: begin
				we    = 1'b1;
				wkey  = a_key_q;
				wpay  = a_pay_q;
			end
			krte_pkg::OP_SWAP: begin
				we    = greater;
				waddr = rd_addr_q;
				wkey  = a_key_q;
				wpay  = a_pay_q;
			end
			krte_pkg::OP_RD_I, krte_pkg::OP_RD_SLOT: rd_en = 1'b1;
			krte_pkg::OP_RD_J: begin
				rd_en = 1'b1;
				raddr = AW'(j_q);
			end
			krte_pkg::OP_RD_INS: begin
				rd_en = 1'b1;
				raddr = AW'(count_q - i_q - CW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			pay_mem[waddr] <= wpay;
		end
		if (rd_en) begin
			rkey_q    <= key_mem[raddr];
			rpay_q    <= pay_mem[raddr];
			rd_addr_q <= raddr;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			krte_pkg::OP_LOAD: begin
				kind_q <= krte_pkg::kind_t'(kind);
				key_q  <= record_key;
				pay_q  <= PAYLOAD_BITS'(record_payload);
				pos_q  <= position;
			end
			krte_pkg::OP_LOAD_A: begin
				a_key_q <= rkey_q;
				a_pay_q <= rpay_q;
			end
			krte_pkg::OP_SWAP: begin
				if (greater) begin
					a_key_q <= rkey_q;
					a_pay_q <= rpay_q;
				end
			end
			default: ;
		endcase
	end

	// walk control and table count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			tot_q    <= '0;
			hit_q    <= 1'b0;
			status_q <= krte_pkg::STAT_OK;
		end else begin
			case (cmd.op)
				krte_pkg::OP_START: begin
					i_q      <= '0;
					j_q      <= '0;
					tot_q    <= '0;
					hit_q    <= 1'b0;
					status_q <= cmd.status;
				end
				krte_pkg::OP_CLEAR: count_q <= '0;
				krte_pkg::OP_APPEND, krte_pkg::OP_INS_PUT: count_q <= count_q + CW'(1);
				krte_pkg::OP_SET_ST: status_q <= cmd.status;
				krte_pkg::OP_RD_I, krte_pkg::OP_RD_INS, krte_pkg::OP_PUT_A: i_q <= i_q + CW'(1);
				krte_pkg::OP_COUNT: if (match) tot_q <= tot_q + CW'(1);
				krte_pkg::OP_REWIND: i_q <= '0;
				krte_pkg::OP_EMIT_REC: j_q <= j_q + CW'(1);
				krte_pkg::OP_UPDATE: if (match) hit_q <= 1'b1;
				krte_pkg::OP_HIT_ST:
					status_q <= hit_q ? krte_pkg::STAT_OK : krte_pkg::STAT_NOT_FOUND;
				krte_pkg::OP_DELETE: begin
					if (match) hit_q <= 1'b1;
					else j_q <= j_q + CW'(1);
				end
				krte_pkg::OP_DEL_END: begin
					count_q  <= j_q;
					status_q <= hit_q ? krte_pkg::STAT_OK : krte_pkg::STAT_NOT_FOUND;
				end
				krte_pkg::OP_RD_SLOT: j_q <= i_q + CW'(1);
				krte_pkg::OP_RD_J: j_q <= j_q + CW'(1);
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.op == krte_pkg::OP_EMIT_REC || cmd.op == krte_pkg::OP_EMIT_ST) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == krte_pkg::OP_EMIT_REC) begin
			entry_key     <= rkey_q;
			entry_payload <= 32'(rpay_q);
			status        <= krte_pkg::STAT_OK;
			has_entry     <= 1'b1;
			entry_count   <= 5'(count_q);
			last          <= ((j_q + CW'(1)) == tot_q);
		end else if (cmd.op == krte_pkg::OP_EMIT_ST) begin
			entry_key     <= '0;
			entry_payload <= '0;
			status        <= status_q;
			has_entry     <= 1'b0;
			entry_count   <= 5'(count_q);
			last          <= 1'b1;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("record count above table depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == krte_pkg::OP_EMIT_REC || cmd.op == krte_pkg::OP_EMIT_ST) |-> !out_busy)
		else $error("result overwritten while stalled");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == krte_pkg::OP_CLEAR |=> count_q == '0)
		else $error("clear left records behind");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == krte_pkg::OP_EMIT_REC |-> j_q < tot_q)
		else $error("more records emitted than counted");

endmodule

`default_nettype wire

/* rtl/keyed_record_table_engine_top.sv */
// Top level of the keyed record table engine: stream ports, sequencer and datapath.
`default_nettype none

// One item is in work at a time; the next transfer is taken once the sequencer is idle, and
// result transfers wait while the output is stalled. Reset (arst_n low) empties the table
// and drops any pending result; memory is not cleared.
module keyed_record_table_engine_top #(
	parameter int TABLE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: record_key[31:0], record_payload[63:32], position[68:64], zero pad
	input  wire  [71:0] s_axis_tdata,
	// tuser: kind[2:0]
	input  wire  [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// tdata: entry_key[31:0], entry_payload[63:32], entry_count[68:64], zero pad
	output logic [71:0] m_axis_tdata,
	// tuser: status[1:0], has_entry[2]
	output logic [2:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	krte_pkg::cmd_t     cmd;
	krte_pkg::dp_stat_t stat;

	logic signed [31:0] entry_key;
	logic [31:0]        entry_payload;
	logic [1:0]         status;
	logic               has_entry;
	logic [4:0]         entry_count;

	// sequencer: one state per step of each table walk
	krte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: hold the records, walk counters and the result register
	krte_dp #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kind           (s_axis_tuser),
		.record_key     (s_axis_tdata[31:0]),
		.record_payload (s_axis_tdata[63:32]),
		.position       (s_axis_tdata[68:64]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.entry_key      (entry_key),
		.entry_payload  (entry_payload),
		.status         (status),
		.has_entry      (has_entry),
		.entry_count    (entry_count),
		.last           (m_axis_tlast)
	);

	// pack the result transfer
	assign m_axis_tdata = {3'b000, entry_count, entry_payload, entry_key};
	assign m_axis_tuser = {has_entry, status};

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the keyed record table engine.
`timescale 1ns / 100ps
`default_nettype none

module tb;

	localparam int DEPTH = 16;
	localparam int CYCLE_LIMIT = 2000000;

	// One expected result as it leaves the block.
	typedef struct packed {
		logic [31:0]       key;
		logic [31:0]       payload;
		logic [4:0]        count;
		krte_pkg::status_t status;
		logic              has_entry;
		logic              last;
	} table_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	wire         s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	wire         m_axis_tvalid;
	logic        m_axis_tready;
	wire  [71:0] m_axis_tdata;
	wire  [2:0]  m_axis_tuser;
	wire         m_axis_tlast;

	// Predicted table contents.
	logic [31:0] shadow_keys [DEPTH];
	logic [31:0] shadow_pays [DEPTH];
	int          shadow_count;

	table_result_t pending_results[$];
	int  error_count;
	int  result_count;
	int  item_count;
	int  cycle_count;
	bit  hold_off;       // receiver hold-off request
	int  hold_cycles;
	bit  no_idle;        // stretches with no gaps at all

	keyed_record_table_engine_top #(
		.TABLE_DEPTH (DEPTH),
		.PAYLOAD_BITS(32)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop on a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at result %0d: %s got %0h expected %0h",
			result_count, what, got, want);
		error_count++;
	endtask

	function automatic table_result_t make_status(krte_pkg::status_t st);
		table_result_t r;
		r = '0;
		r.status = st;
		r.count = shadow_count[4:0];
		r.last = 1'b1;
		return r;
	endfunction

	// Apply one operation to the shadow table and queue what it yields.
	task automatic predict_table_op(input krte_pkg::kind_t kind, input logic [31:0] key,
			input logic [31:0] pay, input logic [4:0] pos);
		table_result_t r;
		int  first_hit;
		int  j;
		bit  hit;
		logic [31:0] tk;
		logic [31:0] tp;
		hit = 0;
		first_hit = pending_results.size();
		case (kind)
			krte_pkg::KIND_CLEAR: begin
				shadow_count = 0;
				pending_results.push_back(make_status(krte_pkg::STAT_OK));
			end
			krte_pkg::KIND_APPEND: begin
				if (shadow_count >= DEPTH) begin
					pending_results.push_back(make_status(krte_pkg::STAT_FULL));
				end else begin
					shadow_keys[shadow_count] = key;
					shadow_pays[shadow_count] = pay;
					shadow_count++;
					pending_results.push_back(make_status(krte_pkg::STAT_OK));
				end
			end
			krte_pkg::KIND_LIST, krte_pkg::KIND_SEARCH: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (kind == krte_pkg::KIND_LIST || shadow_keys[i] == key) begin
						r = make_status(krte_pkg::STAT_OK);
						r.key = shadow_keys[i];
						r.payload = shadow_pays[i];
						r.has_entry = 1'b1;
						r.last = 1'b0;
						pending_results.push_back(r);
						hit = 1;
					end
				end
				if (!hit)
					pending_results.push_back(make_status(
						kind == krte_pkg::KIND_LIST ? krte_pkg::STAT_OK
						                            : krte_pkg::STAT_NOT_FOUND));
				else
					pending_results[pending_results.size() - 1].last = 1'b1;
			end
			krte_pkg::KIND_UPDATE: begin
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_keys[i] == key) begin
						shadow_pays[i] = pay;
						hit = 1;
					end
				end
				pending_results.push_back(make_status(
					hit ? krte_pkg::STAT_OK : krte_pkg::STAT_NOT_FOUND));
			end
			krte_pkg::KIND_DELETE: begin
				j = 0;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_keys[i] == key) begin
						hit = 1;
					end else begin
						shadow_keys[j] = shadow_keys[i];
						shadow_pays[j] = shadow_pays[i];
						j++;
					end
				end
				shadow_count = j;
				pending_results.push_back(make_status(
					hit ? krte_pkg::STAT_OK : krte_pkg::STAT_NOT_FOUND));
			end
			krte_pkg::KIND_INSERT: begin
				if (pos > shadow_count) begin
					pending_results.push_back(make_status(krte_pkg::STAT_BAD_POS));
				end else if (shadow_count >= DEPTH) begin
					pending_results.push_back(make_status(krte_pkg::STAT_FULL));
				end else begin
					for (int i = shadow_count; i > pos; i--) begin
						shadow_keys[i] = shadow_keys[i - 1];
						shadow_pays[i] = shadow_pays[i - 1];
					end
					shadow_keys[pos] = key;
					shadow_pays[pos] = pay;
					shadow_count++;
					pending_results.push_back(make_status(krte_pkg::STAT_OK));
				end
			end
			default: begin
				// exchange sort: slot i against every later slot, signed keys
				for (int i = 0; i < shadow_count; i++) begin
					for (int k = i + 1; k < shadow_count; k++) begin
						if ($signed(shadow_keys[i]) > $signed(shadow_keys[k])) begin
							tk = shadow_keys[i];
							tp = shadow_pays[i];
							shadow_keys[i] = shadow_keys[k];
							shadow_pays[i] = shadow_pays[k];
							shadow_keys[k] = tk;
							shadow_pays[k] = tp;
						end
					end
				end
				pending_results.push_back(make_status(krte_pkg::STAT_OK));
			end
		endcase
	endtask

	// Offer one operation, wait for its transfer, then predict it.
	// Valid stays high after the transfer; the next gap or drain drops it.
	task automatic send_table_op(input krte_pkg::kind_t kind, input logic [31:0] key,
			input logic [31:0] pay, input logic [4:0] pos);
		int gap;
		gap = 0;
		if (!no_idle)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {3'b000, pos, pay, key};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_table_op(kind, key, pay, pos);
		item_count++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Pick a key that is often already held so matches happen.
	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (shadow_count > 0 && sel < 6)
			return shadow_keys[$urandom_range(0, shadow_count - 1)];
		if (sel < 8)
			return $urandom_range(0, 7) - 4;
		return $urandom;
	endfunction

	// Check each result transfer against the oldest expectation.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("unexpected result transfer %0d", result_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== want.key)
					report_mismatch("entry_key", m_axis_tdata[31:0], want.key);
				if (m_axis_tdata[63:32] !== want.payload)
					report_mismatch("entry_payload", m_axis_tdata[63:32], want.payload);
				if (m_axis_tdata[68:64] !== want.count)
					report_mismatch("entry_count", 32'(m_axis_tdata[68:64]),
						32'(want.count));
				if (m_axis_tdata[71:69] !== 3'b000)
					report_mismatch("pad", 32'(m_axis_tdata[71:69]), 32'd0);
				if (m_axis_tuser[1:0] !== want.status)
					report_mismatch("status", 32'(m_axis_tuser[1:0]), 32'(want.status));
				if (m_axis_tuser[2] !== want.has_entry)
					report_mismatch("has_entry", 32'(m_axis_tuser[2]),
						32'(want.has_entry));
				if (m_axis_tlast !== want.last)
					report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
			end
			result_count++;
		end
	end

	// Receiver: random stalls, or a long hold-off when asked.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= 0;
		end else if (hold_off) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles >= 400) begin
				hold_off <= 1'b0;
			end
		end else begin
			hold_cycles <= 0;
			if (no_idle) begin
				m_axis_tready <= 1'b1;
			end else if ($urandom_range(0, 29) == 0) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic test_directed();
		// empty table cases, then fill to full
		send_table_op(krte_pkg::KIND_LIST, 0, 0, 0);
		send_table_op(krte_pkg::KIND_SEARCH, 5, 0, 0);
		send_table_op(krte_pkg::KIND_UPDATE, 5, 1, 0);
		send_table_op(krte_pkg::KIND_DELETE, 5, 0, 0);
		send_table_op(krte_pkg::KIND_SORT, 0, 0, 0);
		send_table_op(krte_pkg::KIND_INSERT, 0, 0, 5'd1);
		send_table_op(krte_pkg::KIND_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 0);
		send_table_op(krte_pkg::KIND_APPEND, 32'h7FFF_FFFF, 32'h0, 0);
		send_table_op(krte_pkg::KIND_APPEND, 32'h7FFF_FFFF, 32'hA5A5_5A5A, 0);
		send_table_op(krte_pkg::KIND_APPEND, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 0);
		for (int i = 0; i < 12; i++)
			send_table_op(krte_pkg::KIND_APPEND, $urandom_range(0, 3) - 1, $urandom, 0);
		send_table_op(krte_pkg::KIND_APPEND, 1, 1, 0);
		send_table_op(krte_pkg::KIND_INSERT, 2, 2, 5'd3);
		send_table_op(krte_pkg::KIND_INSERT, 2, 2, 5'd31);
		send_table_op(krte_pkg::KIND_LIST, 0, 0, 0);
		// adjacent matches: the record that slides down is checked too
		send_table_op(krte_pkg::KIND_DELETE, 32'h7FFF_FFFF, 0, 0);
		send_table_op(krte_pkg::KIND_UPDATE, 0, 32'hDEAD_BEEF, 0);
		send_table_op(krte_pkg::KIND_SORT, 0, 0, 0);
		send_table_op(krte_pkg::KIND_SEARCH, 0, 0, 0);
		send_table_op(krte_pkg::KIND_INSERT, 9, 9, 5'd16);
		send_table_op(krte_pkg::KIND_CLEAR, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_random(input int n);
		krte_pkg::kind_t kind;
		int sel;
		for (int i = 0; i < n; i++) begin
			no_idle = (i % 60) >= 50;
			sel = $urandom_range(0, 99);
			if (sel < 2)
				kind = krte_pkg::KIND_CLEAR;
			else if (sel < 32)
				kind = krte_pkg::KIND_APPEND;
			else if (sel < 42)
				kind = krte_pkg::KIND_LIST;
			else if (sel < 55)
				kind = krte_pkg::KIND_SEARCH;
			else if (sel < 65)
				kind = krte_pkg::KIND_UPDATE;
			else if (sel < 77)
				kind = krte_pkg::KIND_DELETE;
			else if (sel < 92)
				kind = krte_pkg::KIND_INSERT;
			else
				kind = krte_pkg::KIND_SORT;
			send_table_op(kind, pick_key(), $urandom,
				5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
				: $urandom_range(0, shadow_count)));
		end
		no_idle = 0;
	endtask

	// Block the receiver while items keep coming, then pause the sender.
	task automatic test_backpressure();
		hold_off = 1;
		send_table_op(krte_pkg::KIND_CLEAR, 0, 0, 0);
		for (int i = 0; i < 6; i++)
			send_table_op(krte_pkg::KIND_APPEND, i, $urandom, 0);
		send_table_op(krte_pkg::KIND_LIST, 0, 0, 0);
		send_table_op(krte_pkg::KIND_LIST, 0, 0, 0);
		send_table_op(krte_pkg::KIND_SEARCH, 3, 0, 0);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		error_count = 0;
		result_count = 0;
		item_count = 0;
		cycle_count = 0;
		hold_off = 0;
		no_idle = 0;
		shadow_count = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(330);
		wait_drained();
		$display("Sent %0d operations over all kinds, checked %0d results;", item_count,
			result_count);
		$display("covered full table, bad positions, misses and long output stalls.");
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
